### design/wsd_pkg.sv
// shared types and constants for the websocket frame deframer
package wsd_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
	localparam logic [6:0] LEN_EXT16     = 7'd126;
	localparam logic [3:0] EXT_NEED16    = 4'd2;
	localparam logic [3:0] EXT_NEED64    = 4'd8;
	localparam logic [2:0] KEY_NEED      = 3'd4;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_LENGTH  = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic [3:0] frame_opcode;
		logic       final_fragment;
		logic       last_of_message;
		logic       empty_message;
	} result_t;

	// queue status toward the output side
	typedef struct packed {
		logic full;
		logic not_empty;
	} qstat_t;

endpackage

### design/wsd_front.sv
// header parser: takes raw bytes, tracks framing and unmasks payload into the queue
module wsd_front import wsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	output logic       push,
	output result_t    entry
);

	phase_t      phase_q, phase_d;
	logic        fin_q;
	logic [3:0]  opcode_q;
	logic        mask_on_q;
	logic [6:0]  short_len_q;
	logic [3:0]  ext_cnt_q;
	logic [63:0] len_acc_q;
	logic [31:0] key_q;
	logic [2:0]  key_cnt_q;
	logic [63:0] remain_q;
	logic [1:0]  key_idx_q;

	logic [63:0] acc_next;
	logic [3:0]  ext_cnt_inc;
	logic        ext_done;
	logic        ext_zero;
	logic [31:0] key_next;
	logic [2:0]  key_cnt_inc;
	logic        key_done;
	logic [63:0] remain_dec;
	logic        pay_last;
	logic        len_short;
	logic        len_zero;
	logic [7:0]  key_byte;

	assign acc_next    = {len_acc_q[55:0], in_byte};
	assign ext_cnt_inc = ext_cnt_q + 4'd1;
	assign ext_done    = ext_cnt_inc >= ((short_len_q == LEN_EXT16) ? EXT_NEED16 : EXT_NEED64);
	assign ext_zero    = acc_next == 64'd0;
	assign key_next    = {key_q[23:0], in_byte};
	assign key_cnt_inc = key_cnt_q + 3'd1;
	assign key_done    = key_cnt_inc >= KEY_NEED;
	assign remain_dec  = remain_q - 64'd1;
	assign pay_last    = remain_q == 64'd1;
	assign len_short   = in_byte[6:0] <= LEN_MAX_SHORT;
	assign len_zero    = in_byte[6:0] == 7'd0;

	// first key byte sits in the top byte of the key register
	always_comb begin
		unique case (key_idx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q)
				PH_LENGTH: begin
					if (!len_short) phase_d = PH_EXTLEN;
					else if (in_byte[7]) phase_d = PH_KEY;
					else if (len_zero) phase_d = PH_HEADER;
					else phase_d = PH_PAYLOAD;
				end
				PH_EXTLEN: begin
					if (ext_done) begin
						if (mask_on_q) phase_d = PH_KEY;
						else if (ext_zero) phase_d = PH_HEADER;
						else phase_d = PH_PAYLOAD;
					end
				end
				PH_KEY: begin
					if (key_done) phase_d = (remain_q == 64'd0) ? PH_HEADER : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					if (pay_last) phase_d = PH_HEADER;
				end
				default: phase_d = PH_LENGTH;
			endcase
		end
	end

	// outputs toward the queue
	always_comb begin
		push                  = 1'b0;
		entry.payload_byte    = 8'd0;
		entry.frame_opcode    = opcode_q;
		entry.final_fragment  = fin_q;
		entry.last_of_message = 1'b1;
		entry.empty_message   = 1'b1;
		unique case (phase_q)
			PH_LENGTH:  push = accept && len_short && !in_byte[7] && len_zero;
			PH_EXTLEN:  push = accept && ext_done && !mask_on_q && ext_zero;
			PH_KEY:     push = accept && key_done && (remain_q == 64'd0);
			PH_PAYLOAD: begin
				push                  = accept;
				entry.payload_byte    = in_byte ^ (mask_on_q ? key_byte : 8'd0);
				entry.last_of_message = pay_last;
				entry.empty_message   = 1'b0;
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q       <= 1'b0;
			opcode_q    <= 4'd0;
			mask_on_q   <= 1'b0;
			short_len_q <= 7'd0;
			ext_cnt_q   <= 4'd0;
			len_acc_q   <= 64'd0;
			key_q       <= 32'd0;
			key_cnt_q   <= 3'd0;
			remain_q    <= 64'd0;
			key_idx_q   <= 2'd0;
		end else if (accept) begin
			unique case (phase_q)
				PH_LENGTH: begin
					mask_on_q   <= in_byte[7];
					short_len_q <= in_byte[6:0];
					len_acc_q   <= 64'd0;
					ext_cnt_q   <= 4'd0;
					if (len_short) begin
						remain_q  <= {57'd0, in_byte[6:0]};
						key_idx_q <= 2'd0;
						key_cnt_q <= 3'd0;
						key_q     <= 32'd0;
					end
				end
				PH_EXTLEN: begin
					len_acc_q <= acc_next;
					ext_cnt_q <= ext_cnt_inc;
					if (ext_done) begin
						remain_q  <= acc_next;
						key_idx_q <= 2'd0;
						key_cnt_q <= 3'd0;
						key_q     <= 32'd0;
					end
				end
				PH_KEY: begin
					key_q     <= key_next;
					key_cnt_q <= key_cnt_inc;
					if (key_done) key_idx_q <= 2'd0;
				end
				PH_PAYLOAD: begin
					key_idx_q <= key_idx_q + 2'd1;
					remain_q  <= remain_dec;
				end
				default: begin
					fin_q       <= in_byte[7];
					opcode_q    <= in_byte[3:0];
					mask_on_q   <= 1'b0;
					short_len_q <= 7'd0;
					ext_cnt_q   <= 4'd0;
					len_acc_q   <= 64'd0;
					key_q       <= 32'd0;
					key_cnt_q   <= 3'd0;
					remain_q    <= 64'd0;
					key_idx_q   <= 2'd0;
				end
			endcase
		end
	end

endmodule

### design/wsd_queue.sv
// short result queue between the parser and the output register
module wsd_queue import wsd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    pop,
	output result_t pop_data,
	output qstat_t  stat
);

	result_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign stat.full      = count_q == QCNT_W'(QDEPTH);
	assign stat.not_empty = count_q != '0;
	assign pop_data       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			priority if (push && !pop) count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
			else count_q <= count_q;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!stat.full || pop))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> stat.not_empty)
		else $error("queue pop while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + QCNT_W'(1))
		else $error("queue count did not follow push");

endmodule

### design/wsd_back.sv
// output register: drains the queue onto the result channel
module wsd_back import wsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  qstat_t     stat,
	input  result_t    head,
	output logic       pop,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [7:0] payload_byte,
	output logic [3:0] frame_opcode,
	output logic       final_fragment,
	output logic       last_of_message,
	output logic       empty_message
);

	logic    valid_q;
	result_t data_q;
	logic    room;

	// register is free when empty or its request is taken this cycle
	assign room = !valid_q || !out_stall;
	assign pop  = room && stat.not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= stat.not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) data_q <= head;
	end

	assign out_valid       = valid_q;
	assign payload_byte    = data_q.payload_byte;
	assign frame_opcode    = data_q.frame_opcode;
	assign final_fragment  = data_q.final_fragment;
	assign last_of_message = data_q.last_of_message;
	assign empty_message   = data_q.empty_message;

endmodule

### design/websocket_frame_deframer_unit.sv
// websocket frame deframer top level: parser, result queue and output register
// a result enters the queue on its accept edge, then the output register that drives out_valid
// throughput: one byte per cycle; the parser takes a byte every cycle the queue has room
// a four-entry queue lets the parser keep taking bytes while the output side is stalled
// reset: arst_n clears the parser to the header phase and empties the queue and output register
module websocket_frame_deframer_unit import wsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] payload_byte,
	output logic [3:0] frame_opcode,
	output logic       final_fragment,
	output logic       last_of_message,
	output logic       empty_message
);

	logic    accept;
	logic    push;
	logic    pop;
	result_t entry;
	result_t head;
	qstat_t  stat;

	assign in_stall = stat.full;
	assign accept   = in_valid && !stat.full;

	wsd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_byte),
		.push    (push),
		.entry   (entry)
	);

	wsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.pop       (pop),
		.pop_data  (head),
		.stat      (stat)
	);

	wsd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.stat            (stat),
		.head            (head),
		.pop             (pop),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.payload_byte    (payload_byte),
		.frame_opcode    (frame_opcode),
		.final_fragment  (final_fragment),
		.last_of_message (last_of_message),
		.empty_message   (empty_message)
	);

endmodule
